@@ hdl/motor_encoder_wheel_model_macros.svh @@
// assertion macros shared by the encoder wheel model rtl
// no dependencies; included by the modules that carry assertions
`ifndef MOTOR_ENCODER_WHEEL_MODEL_MACROS_SVH
`define MOTOR_ENCODER_WHEEL_MODEL_MACROS_SVH

// property that must hold at every clock edge outside reset
`define MEWM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define MEWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/encw_pkg.sv @@
// shared types and codes for the encoder wheel model
// no dependencies; imported by every module of the block
package encw_pkg;

	localparam int POSITION_W = 8;
	localparam int COUNT_W    = 16;

	localparam logic [POSITION_W-1:0] START_POS = 8'd60;

	// item kinds; any other code just reads
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_SET_DIR = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	// turn directions; any other code means reverse
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic       motor;
		logic [1:0] direction;
	} cmd_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0]    pulse_count;
		logic [POSITION_W-1:0] position;
		logic                  wheel_level;
	} rsp_word_t;

	// per-motor controls for one item
	typedef struct packed {
		logic       step;
		logic       set_dir;
		logic [1:0] direction;
	} wheel_ctl_t;

endpackage

@@ hdl/encw_level.sv @@
// encoder wheel level lookup: constant slot map built at elaboration
// depends on encw_pkg
module encw_level import encw_pkg::*; #(
	parameter int POSITIONS = 128,
	parameter int HOLES     = 16,
	parameter int MASKED    = 1
) (
	input  logic [$clog2(POSITIONS)-1:0] pos,
	output logic                         level
);

	logic [POSITIONS-1:0] slot_map;

	// high on odd half-slots, and over the masked sector at the top of the wheel
	for (genvar g = 0; g < POSITIONS; g++) begin : g_map
		localparam int Half = ((g * 2 * HOLES) / POSITIONS) % 2;
		localparam bit Mask = (MASKED > HOLES) || ((g * HOLES) / POSITIONS >= HOLES - MASKED);
		assign slot_map[g] = (Half != 0) || Mask;
	end

	assign level = slot_map[pos];

endmodule

@@ hdl/encw_wheel.sv @@
// one motor with its encoder wheel: position, direction and edge counter
// depends on encw_pkg, encw_level and the assertion macro header
`include "motor_encoder_wheel_model_macros.svh"

module encw_wheel import encw_pkg::*; #(
	parameter int POSITIONS = 128,
	parameter int HOLES     = 16,
	parameter int MASKED    = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  wheel_ctl_t ctl,
	output rsp_word_t  view
);

	localparam int PW = $clog2(POSITIONS);

	logic [PW-1:0]      pos_q, pos_step, pos_nx;
	logic [1:0]         dir_q, dir_nx;
	logic [COUNT_W-1:0] count_q, count_nx;
	logic               lvl_now, lvl_nx;

	always_comb begin
		unique case (dir_q)
			DIR_STOP: pos_step = pos_q;
			DIR_FWD:  pos_step = (pos_q == PW'(POSITIONS - 1)) ? '0 : pos_q + PW'(1);
			default:  pos_step = (pos_q == '0) ? PW'(POSITIONS - 1) : pos_q - PW'(1);
		endcase
	end

	assign pos_nx = ctl.step ? pos_step : pos_q;

	always_comb begin
		dir_nx = dir_q;
		if (ctl.set_dir) begin
			unique case (ctl.direction)
				DIR_STOP: dir_nx = DIR_STOP;
				DIR_FWD:  dir_nx = DIR_FWD;
				default:  dir_nx = DIR_REV;
			endcase
		end
	end

	encw_level #(.POSITIONS(POSITIONS), .HOLES(HOLES), .MASKED(MASKED)) u_lvl_now (
		.pos   (pos_q),
		.level (lvl_now)
	);

	encw_level #(.POSITIONS(POSITIONS), .HOLES(HOLES), .MASKED(MASKED)) u_lvl_nx (
		.pos   (pos_nx),
		.level (lvl_nx)
	);

	// count a low-to-high wheel transition
	assign count_nx = (ctl.step && !lvl_now && lvl_nx) ? count_q + COUNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= PW'(START_POS);
			dir_q   <= DIR_STOP;
			count_q <= '0;
		end else begin
			pos_q   <= pos_nx;
			dir_q   <= dir_nx;
			count_q <= count_nx;
		end
	end

	assign view.pulse_count = count_nx;
	assign view.position    = POSITION_W'(pos_nx);
	assign view.wheel_level = lvl_nx;

	`MEWM_ASSERT_ALWAYS(a_pos_range, clk, arst_n, 32'(pos_q) < POSITIONS, "position out of range")
	`MEWM_ASSERT_NEXT(a_hold_no_step, clk, arst_n, !ctl.step, $stable(pos_q), "position moved without a tick")
	`MEWM_ASSERT_NEXT(a_stop_holds, clk, arst_n, dir_q == DIR_STOP, $stable(pos_q) && $stable(count_q), "stopped motor moved")
	`MEWM_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + COUNT_W'(1)), "edge count jumped")

endmodule

@@ hdl/motor_encoder_wheel_model.sv @@
// encoder wheel model, top level: input and result registers around the wheel units
// depends on encw_pkg, encw_wheel and encw_level
//
// usage
//   cmd channel (cmd_valid, cmd_stall, cmd) carries one command word: a tick that
//   steps every motor by its direction, a set-direction for one motor, or a read
//   rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one word per command:
//   edge count, position and wheel level of the addressed motor after the command
//   a word moves when valid is high and stall is low at a rising clock edge
// flow and throughput
//   a taken command waits in the input register until the result register can
//   take a word, is then applied to the motor state, and its response is registered
//   into rsp; one command per cycle sustained while rsp_stall is low, as the motor
//   state update and its wheel map lookups are combinational, so ticks wait only on rsp_stall
// reset
//   arst_n clears both pipeline stages; every motor is stopped at position 60
//   with a zero edge count
// stall
//   while rsp_stall holds the response register, the input register keeps
//   its command and cmd_stall rises once that register is full as well
module motor_encoder_wheel_model import encw_pkg::*; #(
	parameter int MOTORS    = 2,
	parameter int POSITIONS = 128,
	parameter int HOLES     = 16,
	parameter int MASKED    = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	// width of a motor index
	localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

	// input stage
	cmd_word_t cmd_s1;
	logic      valid_s1;
	// result stage
	rsp_word_t rsp_s2;
	logic      valid_s2;

	logic          advance;  // result register can take a new word
	logic          fire;     // the command in stage one is applied this cycle
	logic [MW-1:0] sel;      // addressed motor, clamped to the last one
	rsp_word_t     views [MOTORS];
	rsp_word_t     view_sel;

	assign advance   = !(valid_s2 && rsp_stall);
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;

	// a motor number beyond the last motor addresses the last motor
	assign sel = (32'(cmd_s1.motor) >= MOTORS) ? MW'(MOTORS - 1) : MW'(cmd_s1.motor);

	// one wheel unit per motor; ticks reach all, direction changes only the addressed one
	for (genvar g = 0; g < MOTORS; g++) begin : g_motor
		wheel_ctl_t ctl;

		assign ctl.step      = fire && (cmd_s1.kind == KIND_TICK);
		assign ctl.set_dir   = fire && (cmd_s1.kind == KIND_SET_DIR) && (sel == MW'(g));
		assign ctl.direction = cmd_s1.direction;

		encw_wheel #(.POSITIONS(POSITIONS), .HOLES(HOLES), .MASKED(MASKED)) u_wheel (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.view   (views[g])
		);
	end

	// pick the addressed motor's post-command view
	always_comb begin
		view_sel = views[0];
		for (int i = 1; i < MOTORS; i++) begin
			if (sel == MW'(i)) begin
				view_sel = views[i];
			end
		end
	end

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (fire) begin
			rsp_s2 <= view_sel;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule
